### hdl/cpmc_pkg.sv
// ----------------------------------------------------------------------------
// cpmc_pkg
// Shared types, codes and helpers of the cascaded PID motor controller.
// ----------------------------------------------------------------------------
package cpmc_pkg;

    // Encoder counts per mechanical turn and the hard drive bound
    localparam int ENCODER_COUNTS = 8192;
    localparam int HALF_COUNTS    = ENCODER_COUNTS / 2;
    localparam int CURRENT_MAX    = 16384;

    // Scale constants: degrees per turn, milliseconds per second
    localparam int ANGLE_FULL = 360;
    localparam int MS_PER_S   = 1000;

    // Shared arithmetic unit sizes
    localparam int ACC_W     = 80;
    localparam int QUOT_W    = 48;
    localparam int DIV_STEPS = 80;
    localparam int STEP_W    = 6;
    localparam int GAIN_W    = 16;
    localparam int MPLR_W    = 32;

    localparam logic signed [47:0] SAT47   = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [65:0] SAT_HI  = 66'sh7FFF_FFFF_FFFF;
    localparam logic signed [65:0] SAT_LO  = -66'sh7FFF_FFFF_FFFF;

    // Command codes
    localparam logic [3:0] CMD_FEEDBACK     = 4'd0;
    localparam logic [3:0] CMD_TICK         = 4'd1;
    localparam logic [3:0] CMD_CURRENT      = 4'd2;
    localparam logic [3:0] CMD_SPEED        = 4'd3;
    localparam logic [3:0] CMD_POSITION     = 4'd4;
    localparam logic [3:0] CMD_DISABLE      = 4'd5;
    localparam logic [3:0] CMD_ZERO         = 4'd6;
    localparam logic [3:0] CMD_SPEED_CORR   = 4'd7;
    localparam logic [3:0] CMD_CURRENT_CORR = 4'd8;

    // Status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_BAD_ARG = 2'd1;
    localparam logic [1:0] STS_NO_INIT = 2'd2;
    localparam logic [1:0] STS_BAD_CFG = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_PERIOD     = 3'd0;
    localparam logic [2:0] REG_TIMEOUT    = 3'd1;
    localparam logic [2:0] REG_CUR_LIMIT  = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
    localparam logic [2:0] REG_SPD_GAINS  = 3'd4;
    localparam logic [2:0] REG_SPD_ILIMIT = 3'd5;
    localparam logic [2:0] REG_POS_GAINS  = 3'd6;
    localparam logic [2:0] REG_POS_ILIMIT = 3'd7;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_CURRENT,
        MODE_SPEED,
        MODE_POSITION
    } t_mode;

    typedef enum logic {
        LOOP_SPEED,
        LOOP_POS
    } t_loop;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ANG_GO,
        ST_ANG_MUL,
        ST_ANG_DIV,
        ST_ANG_END,
        ST_PID,
        ST_I_MUL,
        ST_I_DIV,
        ST_I_END,
        ST_D_MUL,
        ST_D_DIV,
        ST_D_END,
        ST_K_MUL,
        ST_K_END,
        ST_SPD_ERR,
        ST_DRIVE,
        ST_DONE
    } t_state;

    // Request to the shared multiply / divide unit
    typedef struct packed {
        logic              mul_go;
        logic              div_go;
        logic              acc_clr;
        logic              sgn;
        logic [STEP_W-1:0] steps;
    } t_arith_req;

    // Saturate a wide signed value to +-(2^47-1)
    function automatic logic signed [47:0] sat47(input logic signed [65:0] x);
        logic signed [47:0] r;
        if (x > SAT_HI) begin
            r = SAT47;
        end else if (x < SAT_LO) begin
            r = -SAT47;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

endpackage

### hdl/cpmc_arith.sv
// ----------------------------------------------------------------------------
// cpmc_arith
// Shared shift-add multiplier (one multiplier bit per cycle) and restoring
// divider (one quotient bit per cycle, with an overflow flag on the quotient).
// ----------------------------------------------------------------------------
module cpmc_arith (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cpmc_pkg::t_arith_req  i_req,
    input  logic [79:0]           i_mcand,
    input  logic [31:0]           i_mplier,
    input  logic [79:0]           i_dividend,
    input  logic [31:0]           i_divisor,
    output logic                  o_busy,
    output logic [79:0]           o_acc,
    output logic [47:0]           o_quot,
    output logic                  o_ovf
);
    import cpmc_pkg::*;

    localparam int DCNT_W = $clog2(DIV_STEPS + 1);

    logic [ACC_W-1:0]  r_mcand;
    logic [MPLR_W-1:0] r_mplier;
    logic [STEP_W-1:0] r_mcnt;
    logic              r_sgn;
    logic [ACC_W-1:0]  r_acc;

    logic [ACC_W-1:0]  r_dvd;
    logic [31:0]       r_dsor;
    logic [31:0]       r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic              r_ovf;
    logic [DCNT_W-1:0] r_dcnt;

    logic [ACC_W-1:0]  w_addend;
    logic [32:0]       w_trial;
    logic              w_ge;
    logic [31:0]       w_rem_nx;

    // Partial product of this step; the top bit of a signed multiplier weighs negative
    always_comb begin
        if (!r_mplier[0]) begin
            w_addend = '0;
        end else if (r_sgn && (r_mcnt == STEP_W'(1))) begin
            w_addend = -r_mcand;
        end else begin
            w_addend = r_mcand;
        end
    end

    // Trial subtract of one restoring step
    always_comb begin
        w_trial  = {r_rem, r_dvd[ACC_W-1]};
        w_ge     = (w_trial >= {1'b0, r_dsor});
        w_rem_nx = w_ge ? 32'(w_trial - {1'b0, r_dsor}) : w_trial[31:0];
    end

    // Multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_req.mul_go) begin
            r_mcnt <= i_req.steps;
        end else if (r_mcnt != '0) begin
            r_mcnt <= r_mcnt - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mul_go) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            r_sgn    <= i_req.sgn;
            if (i_req.acc_clr) begin
                r_acc <= '0;
            end
        end else if (r_mcnt != '0) begin
            r_acc    <= r_acc + w_addend;
            r_mcand  <= {r_mcand[ACC_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MPLR_W-1:1]};
        end
    end

    // Divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_req.div_go) begin
            r_dcnt <= DCNT_W'(DIV_STEPS);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.div_go) begin
            r_dvd  <= i_dividend;
            r_dsor <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_dcnt != '0) begin
            r_dvd  <= {r_dvd[ACC_W-2:0], 1'b0};
            r_rem  <= w_rem_nx;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
            r_ovf  <= r_ovf | r_quot[QUOT_W-1];
        end
    end

    assign o_busy = (r_mcnt != '0) || (r_dcnt != '0);
    assign o_acc  = r_acc;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

### hdl/cascaded_pid_motor_controller_core.sv
// ----------------------------------------------------------------------------
// cascaded_pid_motor_controller_core
// Cascaded position / speed PID motor controller with a multi-turn encoder.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Word
//  command   in         i_in_valid / o_in_ready     command, time, frame, setpoint
//  result    out        o_out_valid / i_out_ready   status, drive, online, count, error
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  Feedback, set, disable, zero and correction words pass ST_EXEC and ST_DONE
//  to the result register; a tick in current mode adds ST_DRIVE. Speed and
//  position ticks wait on the shared one-bit-per-cycle multiplier and the 80-step
//  restoring divider that every product and quotient of the laws goes through.
//  One word is in work at a time; the next word is taken while a result waits.
//  Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module cascaded_pid_motor_controller_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_command,
    input  logic [31:0]        i_now_ms,
    input  logic [15:0]        i_encoder_raw,
    input  logic signed [15:0] i_speed_raw,
    input  logic signed [15:0] i_given_current_raw,
    input  logic [7:0]         i_temperature_raw,
    input  logic signed [47:0] i_setpoint,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_current_command,
    output logic               o_online,
    output logic signed [47:0] o_turn_count,
    output logic signed [47:0] o_position_error,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data
);
    import cpmc_pkg::*;

    localparam logic [14:0]       CUR_MAX_15 = 15'(CURRENT_MAX);
    localparam logic signed [17:0] N_S       = 18'(ENCODER_COUNTS);
    localparam logic signed [17:0] HALF_S    = 18'(HALF_COUNTS);
    localparam logic [STEP_W-1:0] DEG_STEPS  = STEP_W'($clog2(ANGLE_FULL + 1));
    localparam logic [STEP_W-1:0] MS_STEPS   = STEP_W'($clog2(MS_PER_S + 1));
    localparam logic [STEP_W-1:0] K_STEPS    = STEP_W'(GAIN_W);
    localparam logic [STEP_W-1:0] T_STEPS    = STEP_W'(MPLR_W);

    t_state r_state, n_state;

    // Latched command word
    logic [3:0]         r_cmd;
    logic [31:0]        r_now;
    logic [15:0]        r_enc;
    logic signed [15:0] r_spd_in;
    logic signed [47:0] r_sp;

    // Configuration
    logic [15:0] r_period, r_timeout, r_maxspd;
    logic [14:0] r_curlim;
    logic [47:0] r_sgains, r_pgains;
    logic [31:0] r_silim, r_pilim;

    // Controller state
    t_mode              r_mode;
    logic               r_online, r_seen, r_tvalid, r_timer;
    logic [15:0]        r_prev_enc;
    logic signed [47:0] r_count;
    logic signed [15:0] r_last_speed;
    logic [31:0]        r_last_fb, r_last_ct;
    logic signed [47:0] r_tgt_cur, r_tgt_spd, r_tgt_pos, r_scorr, r_ccorr;
    logic signed [47:0] r_s_int, r_s_last, r_p_int, r_p_last;
    logic signed [15:0] r_drive;
    logic signed [47:0] r_pos_err;

    // Work registers
    logic [1:0]         r_status;
    logic [31:0]        r_elapsed;
    logic signed [47:0] r_err, r_der;
    logic               r_dneg;
    t_loop              r_loop;
    logic [1:0]         r_kidx;
    logic signed [49:0] r_cur;

    // Result register
    logic               r_ov;
    logic [1:0]         r_o_status;
    logic signed [15:0] r_o_cur;
    logic               r_o_online;
    logic signed [47:0] r_o_count, r_o_perr;

    // Arithmetic unit
    t_arith_req  w_req;
    logic [79:0] w_mcand, w_dvd, w_acc;
    logic [31:0] w_mplier, w_dsor;
    logic [47:0] w_quot;
    logic        w_busy, w_ovf;

    cpmc_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_mcand    (w_mcand),
        .i_mplier   (w_mplier),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsor),
        .o_busy     (w_busy),
        .o_acc      (w_acc),
        .o_quot     (w_quot),
        .o_ovf      (w_ovf)
    );

    // ---------------- combinational datapath ----------------
    logic [31:0]        w_fb_age, w_ct_age;
    logic               w_offline, w_tick_run, w_enc_bad;
    logic signed [17:0] w_d_raw, w_delta;
    logic [14:0]        w_lim;
    logic [47:0]        w_cnt_mag, w_ang_mag, w_der_mag;
    logic signed [47:0] w_ang, w_perr_pos, w_der, w_serr;
    logic signed [47:0] w_integ, w_last, w_int_new;
    logic [47:0]        w_gains;
    logic [31:0]        w_ilim;
    logic signed [50:0] w_inc, w_int_sum, w_ilim51;
    logic signed [48:0] w_diff;
    logic [48:0]        w_diff_mag;
    logic signed [63:0] w_sum, w_sum_adj, w_pid_q;
    logic signed [47:0] w_pid_out;
    logic signed [48:0] w_ts, w_ms, w_ts_cl;
    logic signed [49:0] w_cur_new, w_big, w_vcl;
    logic [49:0]        w_vmag, w_rnd_full;
    logic [15:0]        w_rnd;
    logic signed [15:0] w_drive_new;

    // Timing checks of a tick
    always_comb begin
        w_fb_age   = r_now - r_last_fb;
        w_ct_age   = r_now - r_last_ct;
        w_offline  = !r_seen || (w_fb_age >= {16'd0, r_timeout});
        w_tick_run = !w_offline && (r_mode != MODE_NONE)
                     && (!r_timer || (w_ct_age >= {16'd0, r_period}));
    end

    // Encoder unwrap
    always_comb begin
        w_enc_bad = ({1'b0, r_enc} >= 17'(ENCODER_COUNTS));
        w_d_raw   = $signed({2'b00, r_enc}) - $signed({2'b00, r_prev_enc});
        if (w_d_raw > HALF_S) begin
            w_delta = w_d_raw - N_S;
        end else if (w_d_raw < -HALF_S) begin
            w_delta = w_d_raw + N_S;
        end else begin
            w_delta = w_d_raw;
        end
    end

    // Angle and position error
    always_comb begin
        w_cnt_mag  = r_count[47] ? 48'(-r_count) : 48'(r_count);
        w_ang_mag  = (w_ovf || w_quot[47]) ? 48'(SAT47) : w_quot;
        w_ang      = r_count[47] ? -$signed(w_ang_mag) : $signed(w_ang_mag);
        w_perr_pos = sat47(66'(r_tgt_pos) - 66'(w_ang));
        w_serr     = sat47(66'(r_tgt_spd) - 66'($signed({r_last_speed, 16'd0})));
    end

    // Loop selection
    always_comb begin
        if (r_loop == LOOP_POS) begin
            w_integ = r_p_int;
            w_last  = r_p_last;
            w_gains = r_pgains;
            w_ilim  = r_pilim;
        end else begin
            w_integ = r_s_int;
            w_last  = r_s_last;
            w_gains = r_sgains;
            w_ilim  = r_silim;
        end
    end

    // Integral update with clamp
    always_comb begin
        w_inc     = w_ovf ? $signed({3'b001, 48'd0}) : $signed({3'b000, w_quot});
        w_int_sum = 51'(w_integ) + (r_err[47] ? -w_inc : w_inc);
        w_ilim51  = $signed({19'd0, w_ilim});
        if (w_int_sum > w_ilim51) begin
            w_int_new = w_ilim51[47:0];
        end else if (w_int_sum < -w_ilim51) begin
            w_int_new = 48'(-w_ilim51);
        end else begin
            w_int_new = w_int_sum[47:0];
        end
    end

    // Derivative
    always_comb begin
        w_diff     = 49'(r_err) - 49'(w_last);
        w_diff_mag = w_diff[48] ? 49'(-w_diff) : 49'(w_diff);
        w_der_mag  = (w_ovf || w_quot[47]) ? 48'(SAT47) : w_quot;
        w_der      = r_dneg ? -$signed(w_der_mag) : $signed(w_der_mag);
    end

    // Gain sum, scale by 1/256 toward zero, cascade and drive
    always_comb begin
        w_sum     = $signed(w_acc[63:0]);
        w_sum_adj = w_sum[63] ? (w_sum + 64'sd255) : w_sum;
        w_pid_q   = w_sum_adj >>> 8;
        w_pid_out = sat47(66'(w_pid_q));

        w_ts = 49'(w_pid_out) + 49'(r_scorr);
        w_ms = $signed({17'd0, r_maxspd, 16'd0});
        if (w_ts > w_ms) begin
            w_ts_cl = w_ms;
        end else if (w_ts < -w_ms) begin
            w_ts_cl = -w_ms;
        end else begin
            w_ts_cl = w_ts;
        end

        w_cur_new = 50'(w_pid_out) + 50'(r_ccorr);

        w_lim = (r_curlim > CUR_MAX_15) ? CUR_MAX_15 : r_curlim;
        w_big = $signed({19'd0, w_lim, 16'd0});
        if (r_cur > w_big) begin
            w_vcl = w_big;
        end else if (r_cur < -w_big) begin
            w_vcl = -w_big;
        end else begin
            w_vcl = r_cur;
        end
        w_vmag      = w_vcl[49] ? 50'(-w_vcl) : 50'(w_vcl);
        w_rnd_full  = w_vmag + 50'd32768;
        w_rnd       = w_rnd_full[31:16];
        w_drive_new = w_vcl[49] ? -$signed(w_rnd) : $signed(w_rnd);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                if ((r_cmd == CMD_TICK) && w_tick_run) begin
                    case (r_mode)
                        MODE_CURRENT:  n_state = ST_DRIVE;
                        MODE_SPEED:    n_state = ST_SPD_ERR;
                        MODE_POSITION: n_state = r_tvalid ? ST_ANG_GO : ST_DONE;
                        default:       n_state = ST_DONE;
                    endcase
                end
            end
            ST_ANG_GO:  n_state = ST_ANG_MUL;
            ST_ANG_MUL: if (!w_busy) n_state = ST_ANG_DIV;
            ST_ANG_DIV: if (!w_busy) n_state = ST_ANG_END;
            ST_ANG_END: n_state = ST_PID;
            ST_PID:     n_state = ST_I_MUL;
            ST_I_MUL:   if (!w_busy) n_state = ST_I_DIV;
            ST_I_DIV:   if (!w_busy) n_state = ST_I_END;
            ST_I_END:   n_state = ST_D_MUL;
            ST_D_MUL:   if (!w_busy) n_state = ST_D_DIV;
            ST_D_DIV:   if (!w_busy) n_state = ST_D_END;
            ST_D_END:   n_state = ST_K_MUL;
            ST_K_MUL: begin
                if (!w_busy && (r_kidx == 2'd2)) begin
                    n_state = ST_K_END;
                end
            end
            ST_K_END:   n_state = (r_loop == LOOP_POS) ? ST_SPD_ERR : ST_DRIVE;
            ST_SPD_ERR: n_state = ST_PID;
            ST_DRIVE:   n_state = ST_DONE;
            ST_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs: handshake and arithmetic requests ----------------
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        w_req      = '0;
        w_mcand    = '0;
        w_mplier   = '0;
        w_dvd      = w_acc;
        w_dsor     = 32'(MS_PER_S);
        case (r_state)
            ST_ANG_GO: begin
                w_req.mul_go  = 1'b1;
                w_req.acc_clr = 1'b1;
                w_req.steps   = DEG_STEPS;
                w_mcand       = 80'(w_cnt_mag);
                w_mplier      = 32'(ANGLE_FULL);
            end
            ST_ANG_MUL: begin
                w_req.div_go = !w_busy;
                w_dvd        = {w_acc[63:0], 16'd0};
                w_dsor       = 32'(ENCODER_COUNTS);
            end
            ST_PID: begin
                w_req.mul_go  = 1'b1;
                w_req.acc_clr = 1'b1;
                w_req.steps   = T_STEPS;
                w_mcand       = r_err[47] ? 80'(-r_err) : 80'(r_err);
                w_mplier      = r_elapsed;
            end
            ST_I_MUL: begin
                w_req.div_go = !w_busy;
            end
            ST_I_END: begin
                w_req.mul_go  = 1'b1;
                w_req.acc_clr = 1'b1;
                w_req.steps   = MS_STEPS;
                w_mcand       = 80'(w_diff_mag);
                w_mplier      = 32'(MS_PER_S);
            end
            ST_D_MUL: begin
                w_req.div_go = !w_busy;
                w_dsor       = (r_elapsed == 32'd0) ? 32'd1 : r_elapsed;
            end
            ST_D_END: begin
                w_req.mul_go  = 1'b1;
                w_req.acc_clr = 1'b1;
                w_req.sgn     = 1'b1;
                w_req.steps   = K_STEPS;
                w_mcand       = 80'(r_err);
                w_mplier      = 32'(w_gains[15:0]);
            end
            ST_K_MUL: begin
                w_req.mul_go = !w_busy && (r_kidx != 2'd2);
                w_req.sgn    = 1'b1;
                w_req.steps  = K_STEPS;
                if (r_kidx == 2'd0) begin
                    w_mcand  = 80'(w_integ);
                    w_mplier = 32'(w_gains[31:16]);
                end else begin
                    w_mcand  = 80'(r_der);
                    w_mplier = 32'(w_gains[47:32]);
                end
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // ---------------- state and configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd    <= i_command;
            r_now    <= i_now_ms;
            r_enc    <= i_encoder_raw;
            r_spd_in <= i_speed_raw;
            r_sp     <= i_setpoint;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 16'd1;
            r_timeout <= 16'd100;
            r_curlim  <= 15'd16384;
            r_maxspd  <= '0;
            r_sgains  <= '0;
            r_silim   <= '0;
            r_pgains  <= '0;
            r_pilim   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIOD:     r_period  <= i_cfg_data[15:0];
                REG_TIMEOUT:    r_timeout <= i_cfg_data[15:0];
                REG_CUR_LIMIT:  r_curlim  <= i_cfg_data[14:0];
                REG_MAX_SPEED:  r_maxspd  <= i_cfg_data[15:0];
                REG_SPD_GAINS:  r_sgains  <= i_cfg_data;
                REG_SPD_ILIMIT: r_silim   <= i_cfg_data[31:0];
                REG_POS_GAINS:  r_pgains  <= i_cfg_data;
                REG_POS_ILIMIT: r_pilim   <= i_cfg_data[31:0];
                default:        r_period  <= r_period;
            endcase
        end
    end

    // Controller state per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NONE;
            r_online     <= 1'b0;
            r_seen       <= 1'b0;
            r_tvalid     <= 1'b0;
            r_timer      <= 1'b0;
            r_prev_enc   <= '0;
            r_count      <= '0;
            r_last_speed <= '0;
            r_last_fb    <= '0;
            r_last_ct    <= '0;
            r_tgt_cur    <= '0;
            r_tgt_spd    <= '0;
            r_tgt_pos    <= '0;
            r_scorr      <= '0;
            r_ccorr      <= '0;
            r_s_int      <= '0;
            r_s_last     <= '0;
            r_p_int      <= '0;
            r_p_last     <= '0;
            r_drive      <= '0;
            r_pos_err    <= '0;
            r_status     <= STS_OK;
            r_loop       <= LOOP_SPEED;
            r_kidx       <= '0;
        end else begin
            case (r_state)
                ST_EXEC: begin
                    r_status <= STS_OK;
                    case (r_cmd)
                        CMD_FEEDBACK: begin
                            if (w_enc_bad) begin
                                r_status <= STS_BAD_ARG;
                            end else begin
                                if (!r_tvalid) begin
                                    r_count  <= '0;
                                    r_tvalid <= 1'b1;
                                end else if (r_online) begin
                                    r_count <= r_count + 48'(w_delta);
                                end
                                r_prev_enc   <= r_enc;
                                r_last_speed <= r_spd_in;
                                r_online     <= 1'b1;
                                r_seen       <= 1'b1;
                                r_last_fb    <= r_now;
                            end
                        end
                        CMD_TICK: begin
                            if (w_offline) begin
                                // drop to offline and restart both loops
                                if (r_online) begin
                                    r_online <= 1'b0;
                                    r_timer  <= 1'b0;
                                    r_s_int  <= '0;
                                    r_s_last <= '0;
                                    r_p_int  <= '0;
                                    r_p_last <= '0;
                                end
                                r_drive <= '0;
                            end else if (r_mode == MODE_NONE) begin
                                r_drive <= '0;
                            end else if (w_tick_run) begin
                                r_timer   <= 1'b1;
                                r_last_ct <= r_now;
                                r_elapsed <= r_timer ? w_ct_age : {16'd0, r_period};
                                r_loop    <= (r_mode == MODE_POSITION) ? LOOP_POS
                                                                        : LOOP_SPEED;
                                r_cur     <= 50'(r_tgt_cur);
                                if ((r_mode == MODE_POSITION) && !r_tvalid) begin
                                    r_drive <= '0;
                                end
                            end
                        end
                        CMD_CURRENT, CMD_SPEED, CMD_POSITION: begin
                            if ((r_cmd == CMD_POSITION) && (r_maxspd == 16'd0)) begin
                                r_status <= STS_BAD_CFG;
                            end else begin
                                // new mode restarts loops and control timer
                                if (r_mode != t_mode'(r_cmd - CMD_FEEDBACK - 4'd1)) begin
                                    r_timer  <= 1'b0;
                                    r_s_int  <= '0;
                                    r_s_last <= '0;
                                    r_p_int  <= '0;
                                    r_p_last <= '0;
                                end
                                r_mode <= t_mode'(r_cmd - CMD_FEEDBACK - 4'd1);
                                if (r_cmd == CMD_CURRENT) begin
                                    r_tgt_cur <= r_sp;
                                end else if (r_cmd == CMD_SPEED) begin
                                    r_tgt_spd <= r_sp;
                                end else begin
                                    r_tgt_pos <= r_sp;
                                end
                            end
                        end
                        CMD_DISABLE: begin
                            r_mode    <= MODE_NONE;
                            r_tgt_cur <= '0;
                            r_scorr   <= '0;
                            r_ccorr   <= '0;
                            r_drive   <= '0;
                            r_timer   <= 1'b0;
                            r_s_int   <= '0;
                            r_s_last  <= '0;
                            r_p_int   <= '0;
                            r_p_last  <= '0;
                        end
                        CMD_ZERO: begin
                            if (!r_tvalid) begin
                                r_status <= STS_NO_INIT;
                            end else begin
                                r_count   <= '0;
                                r_tgt_pos <= '0;
                                r_pos_err <= '0;
                                r_timer   <= 1'b0;
                                r_s_int   <= '0;
                                r_s_last  <= '0;
                                r_p_int   <= '0;
                                r_p_last  <= '0;
                            end
                        end
                        CMD_SPEED_CORR:   r_scorr  <= r_sp;
                        CMD_CURRENT_CORR: r_ccorr  <= r_sp;
                        default:          r_status <= STS_BAD_ARG;
                    endcase
                end
                ST_ANG_END: begin
                    r_pos_err <= w_perr_pos;
                    r_err     <= w_perr_pos;
                    r_loop    <= LOOP_POS;
                end
                ST_I_END: begin
                    // integral and last error of the active loop
                    r_dneg <= w_diff[48];
                    if (r_loop == LOOP_POS) begin
                        r_p_int  <= w_int_new;
                        r_p_last <= r_err;
                    end else begin
                        r_s_int  <= w_int_new;
                        r_s_last <= r_err;
                    end
                end
                ST_D_END: begin
                    r_der  <= w_der;
                    r_kidx <= 2'd0;
                end
                ST_K_MUL: begin
                    if (!w_busy && (r_kidx != 2'd2)) begin
                        r_kidx <= r_kidx + 2'd1;
                    end
                end
                ST_K_END: begin
                    if (r_loop == LOOP_POS) begin
                        r_tgt_spd <= w_ts_cl[47:0];
                    end else begin
                        r_cur <= w_cur_new;
                    end
                end
                ST_SPD_ERR: begin
                    r_err  <= w_serr;
                    r_loop <= LOOP_SPEED;
                end
                ST_DRIVE: begin
                    r_drive <= w_drive_new;
                end
                default: begin
                    r_kidx <= r_kidx;
                end
            endcase
        end
    end

    // Result register: load on finish, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == ST_DONE) && (!r_ov || i_out_ready)) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_ov || i_out_ready)) begin
            r_o_status <= r_status;
            r_o_cur    <= r_drive;
            r_o_online <= r_online;
            r_o_count  <= r_count;
            r_o_perr   <= r_pos_err;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_status          = r_o_status;
    assign o_current_command = r_o_cur;
    assign o_online          = r_o_online;
    assign o_turn_count      = r_o_count;
    assign o_position_error  = r_o_perr;

`ifndef SYNTHESIS
    // Arithmetic unit is quiet whenever a new word can be taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy)
        else $error("arithmetic unit busy while idle");

    // No drive without an active mode
    a_none_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NONE) |-> (r_drive == 16'sd0))
        else $error("drive nonzero with no mode");

    // Turn count stays zero until the first accepted frame
    a_count_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tvalid |-> (r_count == 48'sd0))
        else $error("turn count moved before anchoring");

    // Drive never exceeds the hard bound
    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive <= 16'(CURRENT_MAX)) && (r_drive >= -16'(CURRENT_MAX)))
        else $error("drive beyond bound");
`endif

endmodule

### tb/sv/tb_cascaded_pid_motor_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_pid_motor_controller_core
// Self-checking bench: a short table of directed command words, then random
// phases under different register settings. Every accepted word is run
// through a behavioral model of the controller and the result word is compared
// field by field with the model or a typed row. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cascaded_pid_motor_controller_core;

    typedef struct {
        logic [3:0]         cmd;
        logic [31:0]        now;
        logic [15:0]        enc;
        logic signed [15:0] spd;
        logic signed [15:0] cur;
        logic [7:0]         temp;
        logic signed [47:0] sp;
    } t_cmd_word;

    typedef struct {
        logic [1:0]         st;
        logic signed [15:0] drv;
        logic               onl;
        logic signed [47:0] cnt;
        logic signed [47:0] perr;
    } t_res_word;

    typedef struct {
        t_cmd_word w;
        bit        typed;
        t_res_word r;
    } t_dir_row;

    localparam longint LIM47 = 64'sh7FFF_FFFF_FFFF;
    localparam longint CAP62 = 64'sh4000_0000_0000_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [3:0]         i_command = '0;
    logic [31:0]        i_now_ms = '0;
    logic [15:0]        i_encoder_raw = '0;
    logic signed [15:0] i_speed_raw = '0;
    logic signed [15:0] i_given_current_raw = '0;
    logic [7:0]         i_temperature_raw = '0;
    logic signed [47:0] i_setpoint = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [15:0] o_current_command;
    logic               o_online;
    logic signed [47:0] o_turn_count;
    logic signed [47:0] o_position_error;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [47:0]        i_cfg_data = '0;

    cascaded_pid_motor_controller_core dut (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Controller model state
    logic [47:0]        cfg_reg [8];
    cpmc_pkg::t_mode    m_mode;
    bit                 m_en, m_onl, m_seen, m_turns_ok, m_timer_on;
    logic [15:0]        m_prev_enc;
    logic signed [47:0] m_count;
    longint             m_last_speed;
    logic [31:0]        m_fb_time, m_ctl_time;
    longint             m_tgt_cur, m_tgt_spd, m_tgt_pos, m_spd_corr, m_cur_corr;
    longint             m_integ [2];
    longint             m_last_err [2];
    longint             m_drive, m_pos_err;

    t_res_word          expected_q [$];
    int                 mismatches = 0;
    int                 stall_left = 0;
    bit                 rx_calm = 1'b0;

    function automatic longint clip47(input logic signed [79:0] x);
        if (x > LIM47) return LIM47;
        if (x < -LIM47) return -LIM47;
        return longint'(x);
    endfunction

    function automatic logic [63:0] mag64(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function void clear_loops();
        m_integ = '{0, 0};
        m_last_err = '{0, 0};
    endfunction

    function void model_reset();
        cfg_reg = '{48'd1, 48'd100, 48'd16384, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0};
        m_mode = cpmc_pkg::MODE_NONE;
        {m_en, m_onl, m_seen, m_turns_ok, m_timer_on} = '0;
        m_prev_enc = 0; m_fb_time = 0; m_ctl_time = 0;
        m_count = 0; m_last_speed = 0;
        m_tgt_cur = 0; m_tgt_spd = 0; m_tgt_pos = 0; m_spd_corr = 0; m_cur_corr = 0;
        clear_loops();
        m_drive = 0; m_pos_err = 0;
    endfunction

    // Multi-turn count as Q32.16 degrees
    function automatic longint angle_q16();
        logic [63:0] a, q, r;
        longint m;
        a = mag64(longint'(m_count)) * 360;
        q = a / cpmc_pkg::ENCODER_COUNTS;
        r = a % cpmc_pkg::ENCODER_COUNTS;
        if (q >= 64'h8000_0000) m = LIM47;
        else m = longint'((q << 16) + ((r << 16) / cpmc_pkg::ENCODER_COUNTS));
        return (m_count < 0) ? -m : m;
    endfunction

    // One PID evaluation of the given loop
    function automatic longint run_loop(input cpmc_pkg::t_loop lp, input longint err,
                                        input logic [31:0] el);
        logic [47:0] gains, limit;
        logic signed [79:0] kp, ki, kd, e80, i80, d80, dv, sum;
        logic [127:0] prod;
        logic [63:0] inc;
        longint lim, der;
        gains = (lp == cpmc_pkg::LOOP_POS) ? cfg_reg[cpmc_pkg::REG_POS_GAINS]
                                           : cfg_reg[cpmc_pkg::REG_SPD_GAINS];
        limit = (lp == cpmc_pkg::LOOP_POS) ? cfg_reg[cpmc_pkg::REG_POS_ILIMIT]
                                           : cfg_reg[cpmc_pkg::REG_SPD_ILIMIT];
        kp = $signed(gains[15:0]);
        ki = $signed(gains[31:16]);
        kd = $signed(gains[47:32]);
        lim = longint'({32'd0, limit[31:0]});
        prod = 128'(mag64(err)) * 128'(el);
        if (el != 0 && prod > 128'(64'hFFFF_FFFF_FFFF_FFFF)) inc = CAP62;
        else inc = 64'(prod / 1000);
        if (inc > CAP62) inc = CAP62;
        m_integ[lp] += (err < 0) ? -longint'(inc) : longint'(inc);
        if (m_integ[lp] > lim) m_integ[lp] = lim;
        if (m_integ[lp] < -lim) m_integ[lp] = -lim;
        e80 = err;
        d80 = m_last_err[lp];
        dv = {48'd0, ((el != 0) ? el : 32'd1)};
        der = clip47(((e80 - d80) * 1000) / dv);
        m_last_err[lp] = err;
        i80 = m_integ[lp];
        d80 = der;
        sum = kp * e80 + ki * i80 + kd * d80;
        return clip47(sum / 256);
    endfunction

    function automatic longint drive_of(input longint v);
        longint lim, big;
        logic [63:0] r;
        lim = longint'(cfg_reg[cpmc_pkg::REG_CUR_LIMIT][14:0]);
        if (lim > cpmc_pkg::CURRENT_MAX) lim = cpmc_pkg::CURRENT_MAX;
        big = lim * 65536;
        if (v > big) v = big;
        if (v < -big) v = -big;
        r = (mag64(v) + 32768) >> 16;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void control_tick(input logic [31:0] now);
        logic [31:0] el, period;
        longint cur, ms, ts, perr;
        period = {16'd0, cfg_reg[cpmc_pkg::REG_PERIOD][15:0]};
        // Offline: drop loop state and zero the drive
        if (!m_seen || (now - m_fb_time) >= {16'd0, cfg_reg[cpmc_pkg::REG_TIMEOUT][15:0]}) begin
            if (m_onl) begin
                m_onl = 0; clear_loops(); m_timer_on = 0;
            end
            m_drive = 0;
            return;
        end
        if (!m_en || m_mode == cpmc_pkg::MODE_NONE) begin
            m_drive = 0;
            return;
        end
        if (!m_timer_on) begin
            el = period;
            m_timer_on = 1;
        end else begin
            el = now - m_ctl_time;
            if (el < period) return;
        end
        m_ctl_time = now;
        if (m_mode == cpmc_pkg::MODE_CURRENT) begin
            cur = m_tgt_cur;
        end else begin
            if (m_mode == cpmc_pkg::MODE_POSITION) begin
                ms = longint'(cfg_reg[cpmc_pkg::REG_MAX_SPEED][15:0]) * 65536;
                if (!m_turns_ok) begin
                    m_drive = 0;
                    return;
                end
                m_pos_err = clip47(m_tgt_pos - angle_q16());
                ts = run_loop(cpmc_pkg::LOOP_POS, m_pos_err, el) + m_spd_corr;
                if (ts > ms) ts = ms;
                if (ts < -ms) ts = -ms;
                m_tgt_spd = ts;
            end
            perr = clip47(m_tgt_spd - m_last_speed * 65536);
            cur = run_loop(cpmc_pkg::LOOP_SPEED, perr, el) + m_cur_corr;
        end
        m_drive = drive_of(cur);
    endfunction

    function void enter_mode(input cpmc_pkg::t_mode md);
        if (m_mode != md) begin
            clear_loops(); m_timer_on = 0;
        end
        m_mode = md;
        m_en = 1;
    endfunction

    // Apply one command word to the model and return the result word
    function automatic t_res_word predict_word(input t_cmd_word w);
        t_res_word r;
        int d;
        r.st = cpmc_pkg::STS_OK;
        case (w.cmd)
            cpmc_pkg::CMD_FEEDBACK: begin
                if (w.enc >= cpmc_pkg::ENCODER_COUNTS) begin
                    r.st = cpmc_pkg::STS_BAD_ARG;
                end else begin
                    if (!m_turns_ok) begin
                        m_count = 0; m_turns_ok = 1;
                    end else if (m_onl) begin
                        d = int'(w.enc) - int'(m_prev_enc);
                        if (d > cpmc_pkg::HALF_COUNTS) d -= cpmc_pkg::ENCODER_COUNTS;
                        else if (d < -cpmc_pkg::HALF_COUNTS) d += cpmc_pkg::ENCODER_COUNTS;
                        m_count = m_count + 48'(d);
                    end
                    m_prev_enc = w.enc;
                    m_last_speed = w.spd;
                    m_onl = 1; m_seen = 1;
                    m_fb_time = w.now;
                end
            end
            cpmc_pkg::CMD_TICK: control_tick(w.now);
            cpmc_pkg::CMD_CURRENT: begin
                enter_mode(cpmc_pkg::MODE_CURRENT); m_tgt_cur = w.sp;
            end
            cpmc_pkg::CMD_SPEED: begin
                enter_mode(cpmc_pkg::MODE_SPEED); m_tgt_spd = w.sp;
            end
            cpmc_pkg::CMD_POSITION: begin
                if (cfg_reg[cpmc_pkg::REG_MAX_SPEED][15:0] == 0) begin
                    r.st = cpmc_pkg::STS_BAD_CFG;
                end else begin
                    enter_mode(cpmc_pkg::MODE_POSITION); m_tgt_pos = w.sp;
                end
            end
            cpmc_pkg::CMD_DISABLE: begin
                m_en = 0; m_mode = cpmc_pkg::MODE_NONE;
                m_tgt_cur = 0; m_spd_corr = 0; m_cur_corr = 0;
                m_drive = 0; m_timer_on = 0;
                clear_loops();
            end
            cpmc_pkg::CMD_ZERO: begin
                if (!m_turns_ok) begin
                    r.st = cpmc_pkg::STS_NO_INIT;
                end else begin
                    m_count = 0; m_tgt_pos = 0; m_pos_err = 0;
                    m_timer_on = 0;
                    clear_loops();
                end
            end
            cpmc_pkg::CMD_SPEED_CORR: m_spd_corr = w.sp;
            cpmc_pkg::CMD_CURRENT_CORR: m_cur_corr = w.sp;
            default: r.st = cpmc_pkg::STS_BAD_ARG;
        endcase
        r.drv = m_drive[15:0];
        r.onl = m_onl;
        r.cnt = m_count;
        r.perr = m_pos_err[47:0];
        return r;
    endfunction

    // Check result words and randomize the result-side stall
    always @(posedge i_clk) begin
        t_res_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result word, status %0d", $time, o_status);
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.st || o_current_command !== e.drv || o_online !== e.onl ||
                    o_turn_count !== e.cnt || o_position_error !== e.perr) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t mismatch exp st=%0d drv=%0d on=%0d cnt=%0d perr=%0d | got st=%0d drv=%0d on=%0d cnt=%0d perr=%0d",
                                 $time, e.st, e.drv, e.onl, e.cnt, e.perr, o_status,
                                 o_current_command, o_online, o_turn_count, o_position_error);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_calm || $urandom_range(0, 99) < 80) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end
    end

    // Present a word, hold it until taken, then record its expected result
    task automatic send_word(input t_cmd_word w, input bit typed, input t_res_word r);
        t_res_word p;
        i_in_valid <= 1'b1;
        i_command <= w.cmd;
        i_now_ms <= w.now;
        i_encoder_raw <= w.enc;
        i_speed_raw <= w.spd;
        i_given_current_raw <= w.cur;
        i_temperature_raw <= w.temp;
        i_setpoint <= w.sp;
        do @(posedge i_clk); while (!(o_in_ready && i_in_valid));
        p = predict_word(w);
        expected_q.push_back(typed ? r : p);
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        g = (g < 65) ? 0 : (g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [47:0] v [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= v[i];
            cfg_reg[i] = v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [47:0] rand_setpoint();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 48'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
        if (r < 80) return 48'($signed({$urandom, $urandom}) >>> 28);
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] rand_gains(input bit full);
        logic [47:0] g;
        g = {$urandom, $urandom};
        if (full) return g;
        return {48'($signed(g[43:32] ^ 12'h800) >>> 1), 16'($signed(g[27:16]) >>> 3),
                16'($signed(g[11:0]))} ;
    endfunction

    logic [31:0] rnd_now;
    logic [15:0] rnd_enc;

    function automatic t_cmd_word rand_word();
        t_cmd_word w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) rnd_now += $urandom_range(0, 3);
        else if (r < 96) rnd_now += $urandom_range(4, 300);
        else rnd_now = $urandom;
        w.now = rnd_now;
        w.spd = 16'($urandom);
        w.cur = 16'($urandom);
        w.temp = 8'($urandom);
        w.sp = rand_setpoint();
        r = $urandom_range(0, 99);
        if (r < 80) rnd_enc = 16'((int'(rnd_enc) + $urandom_range(0, 600) - 300) & 13'h1FFF);
        else if (r < 92) rnd_enc = 16'($urandom_range(0, 8191));
        w.enc = (r >= 96) ? 16'($urandom_range(8192, 65535)) : rnd_enc;
        if ($urandom_range(0, 3) == 0) w.spd = 16'($signed($urandom_range(0, 400)) - 200);
        r = $urandom_range(0, 99);
        if (r < 30) w.cmd = cpmc_pkg::CMD_FEEDBACK;
        else if (r < 62) w.cmd = cpmc_pkg::CMD_TICK;
        else if (r < 68) w.cmd = cpmc_pkg::CMD_CURRENT;
        else if (r < 74) w.cmd = cpmc_pkg::CMD_SPEED;
        else if (r < 82) w.cmd = cpmc_pkg::CMD_POSITION;
        else if (r < 85) w.cmd = cpmc_pkg::CMD_DISABLE;
        else if (r < 88) w.cmd = cpmc_pkg::CMD_ZERO;
        else if (r < 92) w.cmd = cpmc_pkg::CMD_SPEED_CORR;
        else if (r < 96) w.cmd = cpmc_pkg::CMD_CURRENT_CORR;
        else w.cmd = 4'($urandom_range(9, 15));
        return w;
    endfunction

    // Main stimulus
    initial begin
        t_dir_row    rows [$];
        t_res_word   none, zero_res;
        logic [47:0] regs [8];
        t_cmd_word   w;
        model_reset();
        none = '{cpmc_pkg::STS_OK, 16'sd0, 1'b0, 48'sd0, 48'sd0};
        zero_res = none;
        // Fresh out of reset: error codes and an idle tick
        zero_res.st = cpmc_pkg::STS_BAD_ARG;
        rows.push_back('{'{4'd9, 32'd0, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0}, 1'b1, zero_res});
        rows.push_back('{'{4'd15, 32'hFFFF_FFFF, 16'hFFFF, -16'sd1, -16'sd1, 8'hFF, -48'sd1},
                         1'b1, zero_res});
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd1, 16'd8192, 16'sd0, 16'sd0, 8'd0,
                         48'sd0}, 1'b1, zero_res});
        zero_res.st = cpmc_pkg::STS_NO_INIT;
        rows.push_back('{'{cpmc_pkg::CMD_ZERO, 32'd2, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b1, zero_res});
        zero_res.st = cpmc_pkg::STS_BAD_CFG;
        rows.push_back('{'{cpmc_pkg::CMD_POSITION, 32'd3, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sd1000}, 1'b1, zero_res});
        rows.push_back('{'{cpmc_pkg::CMD_TICK, 32'd4, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b1, none});
        // Feedback, wrap both ways, the current and speed set commands and laws
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd10, 16'd100, 16'sd5, 16'sd7, 8'd40,
                         48'sd0}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_CURRENT, 32'd10, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sh7FFF_FFFF_FFFF}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_TICK, 32'd11, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd11, 16'd8100, 16'sh7FFF, 16'sh7FFF,
                         8'hFF, 48'sd0}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd12, 16'd8191, -16'sh8000, -16'sh8000,
                         8'd0, 48'sd0}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd12, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sd0}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_CURRENT, 32'd12, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         -48'sh8000_0000_0000}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_TICK, 32'd13, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_CURRENT_CORR, 32'd13, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sd98304}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_SPEED_CORR, 32'd13, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         -48'sd65536}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_SPEED, 32'd13, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sd655360}, 1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_TICK, 32'd14, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_ZERO, 32'd14, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_DISABLE, 32'd14, 16'd0, 16'sd0, 16'sd0, 8'd0,
                         48'sd0}, 1'b0, none});
        // Feedback goes stale: tick after the timeout drops online
        rows.push_back('{'{cpmc_pkg::CMD_TICK, 32'd200, 16'd0, 16'sd0, 16'sd0, 8'd0, 48'sd0},
                         1'b0, none});
        rows.push_back('{'{cpmc_pkg::CMD_FEEDBACK, 32'd201, 16'd4000, 16'sd0, 16'sd0, 8'd0,
                         48'sd0}, 1'b0, none});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (rows[i]) begin
            send_word(rows[i].w, rows[i].typed, rows[i].r);
            idle_gap();
        end
        drain();

        // Random phases, each under its own register setting
        rnd_now = $urandom;
        rnd_enc = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: regs = '{48'd1, 48'd2, 48'd16384, 48'd65535, rand_gains(0),
                            48'hFFFF_FFFF, rand_gains(0), 48'hFFFF_FFFF};
                1: regs = '{48'd65535, 48'd65535, 48'd1, 48'd1, rand_gains(1), 48'd0,
                            rand_gains(1), 48'd0};
                5: regs = '{48'd1, 48'd50, 48'($urandom_range(1, 16384)), 48'd0,
                            rand_gains(1), 48'($urandom), rand_gains(1), 48'($urandom)};
                default: regs = '{48'($urandom_range(1, 6)), 48'($urandom_range(2, 300)),
                                  48'($urandom_range(1, 16384)), 48'($urandom_range(1, 3000)),
                                  rand_gains(0), 48'($urandom), rand_gains(0),
                                  48'($urandom)};
            endcase
            write_regs(regs);
            rx_calm = (ph == 2);
            for (int n = 0; n < 225; n++) begin
                w = rand_word();
                send_word(w, 1'b0, none);
                if (n % 75 == 74) drain();
                else if (ph != 2) idle_gap();
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("cascaded_pid_motor_controller_core regression: pass");
        end else begin
            $display("cascaded_pid_motor_controller_core regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("cascaded_pid_motor_controller_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/cpmc_pkg.sv
hdl/cpmc_arith.sv
hdl/cascaded_pid_motor_controller_core.sv
tb/sv/tb_cascaded_pid_motor_controller_core.sv
